// ===== src/bmmd_pkg.sv =====
package bmmd_pkg;

  localparam logic [2:0] TGT_NONE      = 3'd0;
  localparam logic [2:0] TGT_MEM       = 3'd1;
  localparam logic [2:0] TGT_PIA0      = 3'd2;
  localparam logic [2:0] TGT_PIA1      = 3'd3;
  localparam logic [2:0] TGT_VIA       = 3'd4;
  localparam logic [2:0] TGT_CRTC_ADDR = 3'd5;
  localparam logic [2:0] TGT_CRTC_REG  = 3'd6;
  localparam logic [2:0] TGT_CTRL      = 3'd7;

  localparam logic        OP_READ  = 1'b0;
  localparam logic        OP_WRITE = 1'b1;

  localparam logic [15:0] CTRL_ADDR     = 16'hfff0;
  localparam logic [15:0] LOW_MEM_END   = 16'h8000;
  localparam logic [15:0] SCREEN_END    = 16'h9000;
  localparam logic [15:0] BANK_HI_START = 16'hc000;
  localparam logic [15:0] IO_BASE       = 16'he800;
  localparam logic [15:0] IO_END        = 16'hefff;

  // memory control register bits
  localparam int MC_WP_LO   = 0;
  localparam int MC_WP_HI   = 1;
  localparam int MC_BANK_LO = 2;
  localparam int MC_BANK_HI = 3;
  localparam int MC_SCREEN  = 5;
  localparam int MC_IO      = 6;
  localparam int MC_EXP     = 7;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } access_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [16:0] phys;
    logic [3:0]  dev_reg;
    logic        we;
    logic        rd_default;
  } result_t;

  typedef struct packed {
    logic [2:0] target;
    logic [3:0] dev_reg;
  } io_sel_t;

endpackage

// ===== src/banked_memory_map_decoder_core.sv =====
// Bus access decoder for a 128K machine with banked expansion. Each beat on
// the in_ channel is one processor access; one result beat per access comes
// out on the out_ channel through the input register and then the result
// register, and a new access is taken every cycle while out_stall is low.
// The memory control register is loaded by a write to 0xFFF0 when
// cfg_expansion_present is set, and the very next access already decodes
// with the new value. cfg_ready is always high; write cfg only while idle.
module banked_memory_map_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_target,
  output logic [16:0] out_physical_address,
  output logic [3:0]  out_device_register,
  output logic        out_write_enable,
  output logic        out_read_default,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_expansion_present
);
  import bmmd_pkg::*;

  logic    acc_v_r;
  access_t acc_r;
  logic    out_v_r;
  result_t res_r;
  logic    exp_present_r;
  logic [7:0] mc_r;

  result_t res_nxt;
  logic    mc_load;
  logic    advance;
  logic    commit;
  logic    acc_load;

  assign advance = !out_v_r || !out_stall;
  assign commit  = acc_v_r && advance;
  // input register takes a beat when it is empty or moving on
  assign acc_load = advance || !acc_v_r;
  assign in_stall = acc_v_r && !advance;
  assign cfg_ready = 1'b1;

  bmmd_decode u_dec (
    .acc         (acc_r),
    .mc          (mc_r),
    .exp_present (exp_present_r),
    .res         (res_nxt),
    .mc_load     (mc_load)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r       <= 1'b0;
      out_v_r       <= 1'b0;
      exp_present_r <= 1'b0;
      mc_r          <= 8'd0;
    end else begin
      if (acc_load) begin
        acc_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= acc_v_r;
      end
      if (cfg_valid && cfg_ready) begin
        exp_present_r <= cfg_expansion_present;
      end
      if (commit && mc_load) begin
        mc_r <= acc_r.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_load) begin
      acc_r.op    <= in_operation;
      acc_r.addr  <= in_address;
      acc_r.wdata <= in_write_data;
    end
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_target           = res_r.target;
  assign out_physical_address = res_r.phys;
  assign out_device_register  = res_r.dev_reg;
  assign out_write_enable     = res_r.we;
  assign out_read_default     = res_r.rd_default;

  a_phys_only_mem: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (res_r.target != TGT_MEM) |-> (res_r.phys == 17'd0))
    else $error("physical address set for a non-memory target");

  a_we_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(res_r.we && res_r.rd_default))
    else $error("write enable and read default together");

  a_mc_only_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(mc_r) |->
      $past(commit && mc_load && exp_present_r && acc_r.op == OP_WRITE))
    else $error("memory control changed without a control register write");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> acc_v_r && out_v_r && out_stall)
    else $error("input stalled with free pipeline");

endmodule

// ===== src/bmmd_io_decode.sv =====
module bmmd_io_decode (
  input  logic [10:0]      offset,
  input  logic             wr,
  output bmmd_pkg::io_sel_t sel
);
  import bmmd_pkg::*;

  always_comb begin
    sel.target  = TGT_NONE;
    sel.dev_reg = 4'd0;
    if (offset[10:2] == 9'h004) begin
      sel.target  = TGT_PIA0;
      sel.dev_reg = {2'b00, offset[1:0]};
    end else if (offset[10:2] == 9'h008) begin
      sel.target  = TGT_PIA1;
      sel.dev_reg = {2'b00, offset[1:0]};
    end else if (offset[10:4] == 7'h04) begin
      sel.target  = TGT_VIA;
      sel.dev_reg = offset[3:0];
    end else if (offset == 11'h080 && wr) begin
      sel.target  = TGT_CRTC_ADDR;   // address latch is write only
    end else if (offset == 11'h081) begin
      sel.target  = TGT_CRTC_REG;
    end
  end

endmodule

// ===== src/bmmd_decode.sv =====
module bmmd_decode (
  input  bmmd_pkg::access_t acc,
  input  logic [7:0]        mc,
  input  logic              exp_present,
  output bmmd_pkg::result_t res,
  output logic              mc_load
);
  import bmmd_pkg::*;

  logic        wr;
  logic        exp_on;
  logic        in_io;
  io_sel_t     io_sel;
  logic [2:0]  tgt;
  logic [16:0] phys;
  logic [3:0]  dreg;
  logic        we;

  assign wr     = (acc.op == OP_WRITE);
  assign exp_on = mc[MC_EXP];
  assign in_io  = (acc.addr >= IO_BASE) && (acc.addr <= IO_END);

  bmmd_io_decode u_io (
    .offset (acc.addr[10:0]),
    .wr     (wr),
    .sel    (io_sel)
  );

  always_comb begin
    tgt     = TGT_MEM;
    phys    = 17'd0;
    dreg    = 4'd0;
    we      = 1'b0;
    mc_load = 1'b0;
    if (acc.addr == CTRL_ADDR) begin
      if (!wr) begin
        phys = {1'b0, CTRL_ADDR};
      end else if (exp_present) begin
        tgt     = TGT_CTRL;
        we      = 1'b1;
        mc_load = 1'b1;
      end else begin
        tgt = TGT_NONE;
      end
    end else if (acc.addr < LOW_MEM_END) begin
      phys = {1'b0, acc.addr};
      we   = wr;
    end else if (in_io && (!exp_on || mc[MC_IO])) begin
      tgt  = io_sel.target;
      dreg = io_sel.dev_reg;
      we   = wr && (io_sel.target != TGT_NONE);
    end else if (!exp_on) begin
      phys = {1'b0, acc.addr};
      we   = wr && (acc.addr < SCREEN_END);
    end else if (acc.addr < BANK_HI_START) begin
      if (acc.addr < SCREEN_END && mc[MC_SCREEN]) begin
        phys = {1'b0, acc.addr};   // screen peek-through
        we   = wr;
      end else begin
        phys = {2'b10, mc[MC_BANK_LO], acc.addr[13:0]};
        we   = wr && !mc[MC_WP_LO];
      end
    end else begin
      phys = {2'b11, mc[MC_BANK_HI], acc.addr[13:0]};
      we   = wr && !mc[MC_WP_HI];
    end
  end

  always_comb begin
    res.target     = tgt;
    res.phys       = (tgt == TGT_MEM) ? phys : 17'd0;
    res.dev_reg    = dreg;
    res.we         = we;
    res.rd_default = !wr && (tgt == TGT_NONE);
  end

endmodule
